// File: rtl/tts_pkg.sv
// Shared types and constants for the tick task scheduler.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int SLOT_W    = 3;
    localparam int IDX_W     = 4;
    localparam int TAG_W     = 8;
    localparam int TIME_W    = 16;
    localparam int RUNS_W    = 8;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_ADD      = 2'd2;
    localparam logic [1:0] CMD_DELETE   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NONE  = 2'd2;

    localparam logic [IDX_W-1:0]  NO_SLOT  = IDX_W'(MAX_TASKS);
    localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

    typedef struct packed {
        logic [1:0]        command;
        logic [TAG_W-1:0]  task_tag;
        logic [TIME_W-1:0] first_delay;
        logic [TIME_W-1:0] repeat_period;
        logic [SLOT_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic [TAG_W-1:0] run_tag;
        logic             run_now;
        logic [1:0]       status;
        logic             last;
    } result_t;

    // Command token that walks the row of slot cells.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [1:0]        command;
        logic [TAG_W-1:0]  task_tag;
        logic [TIME_W-1:0] first_delay;
        logic [TIME_W-1:0] repeat_period;
        logic [SLOT_W-1:0] slot;
    } tok_t;

    // Result raised by a cell while it holds the token.
    typedef struct packed {
        logic             valid;
        logic             run;
        logic [IDX_W-1:0] slot_index;
        logic [TAG_W-1:0] run_tag;
    } emit_t;

endpackage

// File: rtl/tts_cell.sv
// One task slot: holds its state and applies the passing command token.
`timescale 1ns / 1ps

module tts_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [tts_pkg::SLOT_W-1:0] cell_idx,
    input  tts_pkg::tok_t             tok_in,
    output tts_pkg::tok_t             tok_out,
    output tts_pkg::emit_t            emit
);

    logic                        used_reg,    used_next;
    logic [tts_pkg::TAG_W-1:0]   tag_reg,     tag_next;
    logic [tts_pkg::TIME_W-1:0]  delay_reg,   delay_next;
    logic [tts_pkg::TIME_W-1:0]  period_reg,  period_next;
    logic [tts_pkg::RUNS_W-1:0]  pending_reg, pending_next;
    tts_pkg::tok_t               tok_reg,     tok_next;

    always_comb
    begin
        used_next    = used_reg;
        tag_next     = tag_reg;
        delay_next   = delay_reg;
        period_next  = period_reg;
        pending_next = pending_reg;
        tok_next     = tok_in;
        emit         = '0;
        emit.slot_index = tts_pkg::IDX_W'(cell_idx);

        if (advance && tok_in.valid)
        begin
            unique case (tok_in.command)
                tts_pkg::CMD_TICK:
                begin
                    if (used_reg)
                    begin
                        if (delay_reg == '0)
                        begin
                            if (pending_reg != tts_pkg::RUNS_MAX)
                            begin
                                pending_next = pending_reg + 1'b1;
                            end
                            if (period_reg != '0)
                            begin
                                delay_next = period_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            delay_next = delay_reg - 1'b1;
                        end
                    end
                end
                tts_pkg::CMD_DISPATCH:
                begin
                    if (used_reg && pending_reg != '0)
                    begin
                        emit.valid     = 1'b1;
                        emit.run       = 1'b1;
                        emit.run_tag   = tag_reg;
                        tok_next.found = 1'b1;
                        pending_next   = pending_reg - 1'b1;
                        // A one-shot task leaves the table once it has run.
                        if (period_reg == '0)
                        begin
                            used_next    = 1'b0;
                            tag_next     = '0;
                            delay_next   = '0;
                            pending_next = '0;
                        end
                    end
                end
                tts_pkg::CMD_ADD:
                begin
                    if (!tok_in.found && !used_reg)
                    begin
                        emit.valid     = 1'b1;
                        tok_next.found = 1'b1;
                        used_next      = 1'b1;
                        tag_next       = tok_in.task_tag;
                        delay_next     = tok_in.first_delay;
                        period_next    = tok_in.repeat_period;
                        pending_next   = '0;
                    end
                end
                tts_pkg::CMD_DELETE:
                begin
                    if (tok_in.slot == cell_idx)
                    begin
                        used_next    = 1'b0;
                        tag_next     = '0;
                        delay_next   = '0;
                        period_next  = '0;
                        pending_next = '0;
                    end
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= 1'b0;
            tag_reg     <= '0;
            delay_reg   <= '0;
            period_reg  <= '0;
            pending_reg <= '0;
            tok_reg     <= '0;
        end
        else
        begin
            used_reg    <= used_next;
            tag_reg     <= tag_next;
            delay_reg   <= delay_next;
            period_reg  <= period_next;
            pending_reg <= pending_next;
            if (advance)
            begin
                tok_reg <= tok_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/tick_task_scheduler.sv
// Top level of the tick task scheduler: entry stage, slot cell row, result staging.
// A command token walks the row of MAX_TASKS slot cells, one cell per cycle when
// the result side does not stall. A new command is taken only after the previous
// token has left the row; result stalls pause the row.
// Reset (rst_n low, asynchronous) empties every slot and drops any token in flight.
`timescale 1ns / 1ps

module tick_task_scheduler (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  tts_pkg::cmd_t     cmd,
    output logic              result_valid,
    input  logic              result_stall,
    output tts_pkg::result_t  result
);

    tts_pkg::tok_t    tok_chain [tts_pkg::MAX_TASKS+1];
    tts_pkg::emit_t   cell_emit [tts_pkg::MAX_TASKS];
    tts_pkg::emit_t   emit_any;
    tts_pkg::tok_t    entry_reg;
    tts_pkg::tok_t    tail_tok;
    tts_pkg::result_t hold_reg,       hold_next;
    logic             hold_valid_reg, hold_valid_next;
    tts_pkg::result_t out_reg,        out_next;
    logic             out_valid_reg,  out_valid_next;
    logic             advance;
    logic             busy;
    logic             cmd_take;
    logic [tts_pkg::MAX_TASKS:0] tok_valids;

    // The row moves whenever the output register is free or being drained.
    assign advance  = !out_valid_reg || !result_stall;
    assign cmd_take = cmd_valid && !cmd_stall;
    assign cmd_stall = busy;

    assign tok_chain[0] = entry_reg;
    assign tail_tok     = tok_chain[tts_pkg::MAX_TASKS];

    genvar k;
    generate
        for (k = 0; k < tts_pkg::MAX_TASKS; k++)
        begin : g_cell
            tts_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .cell_idx (tts_pkg::SLOT_W'(k)),
                .tok_in   (tok_chain[k]),
                .tok_out  (tok_chain[k+1]),
                .emit     (cell_emit[k])
            );
        end
        for (k = 0; k <= tts_pkg::MAX_TASKS; k++)
        begin : g_valid
            assign tok_valids[k] = tok_chain[k].valid;
        end
    endgenerate

    assign busy = |tok_valids;

    // Only the cell that raised a result contributes its slot number.
    always_comb
    begin
        emit_any = '0;
        for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
        begin
            if (cell_emit[i].valid)
            begin
                emit_any = emit_any | cell_emit[i];
            end
        end
    end

    // A raised result waits in the hold stage until it is known whether
    // another one follows, which decides its last flag.
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && result_stall;

        if (advance)
        begin
            if (emit_any.valid)
            begin
                if (hold_valid_reg)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                end
                hold_valid_next      = 1'b1;
                hold_next.slot_index = emit_any.slot_index;
                hold_next.run_tag    = emit_any.run_tag;
                hold_next.run_now    = emit_any.run;
                hold_next.status     = tts_pkg::STATUS_OK;
                hold_next.last       = 1'b0;
            end
            else if (tail_tok.valid)
            begin
                if (hold_valid_reg)
                begin
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                end
                else if (tail_tok.command == tts_pkg::CMD_DISPATCH ||
                         tail_tok.command == tts_pkg::CMD_ADD)
                begin
                    out_next.slot_index = tts_pkg::NO_SLOT;
                    out_next.run_tag    = '0;
                    out_next.run_now    = 1'b0;
                    out_next.status     = (tail_tok.command == tts_pkg::CMD_ADD) ?
                                          tts_pkg::STATUS_FULL : tts_pkg::STATUS_NONE;
                    out_next.last       = 1'b1;
                    out_valid_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                entry_reg.valid         <= 1'b1;
                entry_reg.found         <= 1'b0;
                entry_reg.command       <= cmd.command;
                entry_reg.task_tag      <= cmd.task_tag;
                entry_reg.first_delay   <= cmd.first_delay;
                entry_reg.repeat_period <= cmd.repeat_period;
                entry_reg.slot          <= cmd.slot;
            end
            else if (advance)
            begin
                entry_reg.valid <= 1'b0;
            end
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef NO_ASSERTIONS
    logic [tts_pkg::MAX_TASKS-1:0] emit_valids;

    always_comb
    begin
        for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
        begin
            emit_valids[i] = cell_emit[i].valid;
        end
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valids))
        else $error("more than one command token in the slot row");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit_valids))
        else $error("several slot cells raised a result in one cycle");

    a_hold_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> busy)
        else $error("held result with no command in flight");

    // The entry stage may still take a command while a result is stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            $stable(hold_reg) && $stable(tok_valids[tts_pkg::MAX_TASKS:1]))
        else $error("slot row moved while a result was stalled");
`endif

endmodule

// File: verif/tts_reply_checker.sv
// Reply checker for the tick task scheduler: slot table model and reply comparison.
`timescale 1ns / 1ps

module tts_reply_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_stall,
    input  tts_pkg::cmd_t    cmd,
    input  logic             result_valid,
    input  logic             result_stall,
    input  tts_pkg::result_t result,
    output int               mismatch_count,
    output int               replies_outstanding
);

    logic                       entry_used   [tts_pkg::MAX_TASKS];
    logic [tts_pkg::TAG_W-1:0]  entry_tag    [tts_pkg::MAX_TASKS];
    logic [tts_pkg::TIME_W-1:0] entry_delay  [tts_pkg::MAX_TASKS];
    logic [tts_pkg::TIME_W-1:0] entry_period [tts_pkg::MAX_TASKS];
    logic [tts_pkg::RUNS_W-1:0] entry_runs   [tts_pkg::MAX_TASKS];

    tts_pkg::result_t pending_replies [$];
    tts_pkg::result_t oldest_reply;
    int               mismatches = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    function automatic void free_entry(input int i);
        entry_used[i]   = 1'b0;
        entry_tag[i]    = '0;
        entry_delay[i]  = '0;
        entry_period[i] = '0;
        entry_runs[i]   = '0;
    endfunction

    function automatic void push_reply(input int idx, input logic [tts_pkg::TAG_W-1:0] tag,
                                       input logic run, input logic [1:0] status,
                                       input logic is_last);
        tts_pkg::result_t r;
        r.slot_index = tts_pkg::IDX_W'(idx);
        r.run_tag    = tag;
        r.run_now    = run;
        r.status     = status;
        r.last       = is_last;
        pending_replies.push_back(r);
    endfunction

    // Updates the slot table for one accepted command and queues its replies.
    function automatic void apply_command(input tts_pkg::cmd_t c);
        int last_ready;
        int free_idx;
        last_ready = -1;
        free_idx   = -1;
        case (c.command)
            tts_pkg::CMD_TICK:
            begin
                for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
                begin
                    if (entry_used[i])
                    begin
                        if (entry_delay[i] == '0)
                        begin
                            if (entry_runs[i] != tts_pkg::RUNS_MAX)
                                entry_runs[i] = entry_runs[i] + 1'b1;
                            if (entry_period[i] != '0)
                                entry_delay[i] = entry_period[i] - 1'b1;
                        end
                        else
                        begin
                            entry_delay[i] = entry_delay[i] - 1'b1;
                        end
                    end
                end
            end
            tts_pkg::CMD_DISPATCH:
            begin
                for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
                    if (entry_used[i] && entry_runs[i] != '0)
                        last_ready = i;
                if (last_ready < 0)
                begin
                    push_reply(tts_pkg::MAX_TASKS, '0, 1'b0, tts_pkg::STATUS_NONE, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
                    begin
                        if (entry_used[i] && entry_runs[i] != '0)
                        begin
                            push_reply(i, entry_tag[i], 1'b1, tts_pkg::STATUS_OK,
                                       i == last_ready);
                            entry_runs[i] = entry_runs[i] - 1'b1;
                            // A one-shot task leaves the table even with runs still owed.
                            if (entry_period[i] == '0)
                                free_entry(i);
                        end
                    end
                end
            end
            tts_pkg::CMD_ADD:
            begin
                for (int i = tts_pkg::MAX_TASKS - 1; i >= 0; i--)
                    if (!entry_used[i])
                        free_idx = i;
                if (free_idx < 0)
                begin
                    push_reply(tts_pkg::MAX_TASKS, '0, 1'b0, tts_pkg::STATUS_FULL, 1'b1);
                end
                else
                begin
                    entry_used[free_idx]   = 1'b1;
                    entry_tag[free_idx]    = c.task_tag;
                    entry_delay[free_idx]  = c.first_delay;
                    entry_period[free_idx] = c.repeat_period;
                    entry_runs[free_idx]   = '0;
                    push_reply(free_idx, '0, 1'b0, tts_pkg::STATUS_OK, 1'b1);
                end
            end
            default:
            begin
                if (int'(c.slot) < tts_pkg::MAX_TASKS)
                    free_entry(int'(c.slot));
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
                free_entry(i);
            pending_replies.delete();
        end
        else
        begin
            // Replies are matched before the new command is modeled, so a reply
            // can never be paired with a command accepted at the same edge.
            if (result_valid && !result_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    report_mismatch("reply with nothing outstanding", int'(result), -1);
                end
                else
                begin
                    oldest_reply = pending_replies.pop_front();
                    check_field("slot_index", result.slot_index, oldest_reply.slot_index);
                    check_field("run_tag", result.run_tag, oldest_reply.run_tag);
                    check_field("run_now", result.run_now, oldest_reply.run_now);
                    check_field("status", result.status, oldest_reply.status);
                    check_field("last", result.last, oldest_reply.last);
                end
            end
            if (cmd_valid && !cmd_stall)
                apply_command(cmd);
        end
        replies_outstanding <= pending_replies.size();
        mismatch_count      <= mismatches;
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the tick task scheduler: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_NONE   = 0;
    localparam int STALL_LIGHT  = 1;
    localparam int STALL_HEAVY  = 2;
    localparam int STALL_TOGGLE = 3;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_COMMANDS  = 100;
    localparam int SATURATE_TICKS   = 260;
    localparam int SETTLE_CYCLES    = 4 * (tts_pkg::MAX_TASKS + 2);

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             cmd_valid    = 1'b0;
    logic             cmd_stall;
    tts_pkg::cmd_t    cmd          = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    tts_pkg::result_t result;

    int mismatch_count;
    int replies_outstanding;
    bit hold_request = 1'b0;

    tick_task_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    tts_reply_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd_valid           (cmd_valid),
        .cmd_stall           (cmd_stall),
        .cmd                 (cmd),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .result              (result),
        .mismatch_count      (mismatch_count),
        .replies_outstanding (replies_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

    // Reply side: a stall pattern that changes mode now and then, plus one long
    // hold-off on request, counted here cycle by cycle.
    initial
    begin
        int   mode;
        int   mode_left;
        int   hold_left;
        bit   hold_taken;
        logic stall_next;
        mode       = STALL_NONE;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        stall_next = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                stall_next = 1'b1;
                hold_left--;
            end
            else if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(STALL_NONE, STALL_TOGGLE);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:   stall_next = 1'b0;
                    STALL_LIGHT:  stall_next = ($urandom_range(0, 99) < 25);
                    STALL_HEAVY:  stall_next = ($urandom_range(0, 99) < 70);
                    default:      stall_next = ~stall_next;
                endcase
            end
            result_stall <= stall_next;
        end
    end

    function automatic tts_pkg::cmd_t make_command(input logic [1:0] op, input int tag,
                                                   input int delay, input int period,
                                                   input int slot_no);
        tts_pkg::cmd_t c;
        c.command       = op;
        c.task_tag      = tts_pkg::TAG_W'(tag);
        c.first_delay   = tts_pkg::TIME_W'(delay);
        c.repeat_period = tts_pkg::TIME_W'(period);
        c.slot          = tts_pkg::SLOT_W'(slot_no);
        return c;
    endfunction

    // Mostly short delays and periods so that tasks come due; now and then a
    // full-range value so that every bit of the time fields moves.
    function automatic tts_pkg::cmd_t random_command();
        tts_pkg::cmd_t c;
        int            pick;
        pick            = $urandom_range(0, 99);
        c.task_tag      = tts_pkg::TAG_W'($urandom);
        c.first_delay   = ($urandom_range(0, 9) == 0) ? tts_pkg::TIME_W'($urandom)
                                                      : tts_pkg::TIME_W'($urandom_range(0, 5));
        c.repeat_period = ($urandom_range(0, 9) == 0) ? tts_pkg::TIME_W'($urandom)
                        : ($urandom_range(0, 2) == 0) ? '0
                                                      : tts_pkg::TIME_W'($urandom_range(1, 6));
        c.slot          = tts_pkg::SLOT_W'($urandom_range(0, tts_pkg::MAX_TASKS - 1));
        if (pick < 40)
            c.command = tts_pkg::CMD_TICK;
        else if (pick < 65)
            c.command = tts_pkg::CMD_DISPATCH;
        else if (pick < 90)
            c.command = tts_pkg::CMD_ADD;
        else
            c.command = tts_pkg::CMD_DELETE;
        return c;
    endfunction

    // Offers one command from the next falling edge and holds it until a transfer.
    task automatic send_command(input tts_pkg::cmd_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        forever
        begin
            @(posedge clk);
            if (!cmd_stall)
                break;
        end
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        idle_cycles(1);
        while (replies_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        tts_pkg::cmd_t directed [$];
        int            sent;
        int            burst_len;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table, filling the table with edge values, full table, due and
        // one-shot tasks, deletes at both ends of the slot range.
        directed.push_back(make_command(tts_pkg::CMD_DISPATCH, 8'h33, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'hFF, 65535, 65535, 7));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h5A, 0, 1, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'hA5, 1, 2, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h3C, 2, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'hC3, 0, 65535, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h0F, 65535, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'hF0, 0, 3, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h81, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_TICK, 8'hFF, 65535, 65535, 7));
        directed.push_back(make_command(tts_pkg::CMD_DISPATCH, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_TICK, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_TICK, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_TICK, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_DISPATCH, 8'hFF, 65535, 65535, 7));
        directed.push_back(make_command(tts_pkg::CMD_DELETE, 8'h00, 0, 0, 7));
        directed.push_back(make_command(tts_pkg::CMD_DELETE, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_ADD, 8'h7E, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_DELETE, 8'hFF, 65535, 65535, 1));
        directed.push_back(make_command(tts_pkg::CMD_TICK, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_DISPATCH, 8'h00, 0, 0, 0));
        directed.push_back(make_command(tts_pkg::CMD_DISPATCH, 8'h00, 0, 0, 0));
        foreach (directed[i])
        begin
            send_command(directed[i]);
            idle_cycles($urandom_range(0, 2));
        end
        wait_drained();

        // Pending runs saturate: a one-shot and a periodic task that are due on
        // every tick, then dispatches that drain the one-shot and keep the other.
        for (int i = 0; i < tts_pkg::MAX_TASKS; i++)
            send_command(make_command(tts_pkg::CMD_DELETE, 0, 0, 0, i));
        send_command(make_command(tts_pkg::CMD_ADD, 8'h11, 0, 0, 0));
        send_command(make_command(tts_pkg::CMD_ADD, 8'h22, 0, 1, 0));
        repeat (SATURATE_TICKS) send_command(make_command(tts_pkg::CMD_TICK, 0, 0, 0, 0));
        repeat (3) send_command(make_command(tts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
        wait_drained();

        // Long reply hold-off while commands keep coming, so the block backs up.
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 2)
                send_command(make_command(tts_pkg::CMD_DISPATCH, 0, 0, 0, 0));
            else
                send_command(make_command(tts_pkg::CMD_ADD, $urandom, $urandom_range(0, 3),
                                          $urandom_range(0, 3), 0));
        end
        wait_drained();

        sent = 0;
        while (sent < RANDOM_COMMANDS)
        begin
            burst_len = $urandom_range(1, 12);
            for (int i = 0; i < burst_len && sent < RANDOM_COMMANDS; i++)
            begin
                send_command(random_command());
                sent++;
            end
            if (sent == RANDOM_COMMANDS / 2)
                wait_drained();
            else if ($urandom_range(0, 3) != 0)
                idle_cycles(($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                        : $urandom_range(1, 3));
        end
        wait_drained();

        if (mismatch_count == 0 && replies_outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: tick_task_scheduler.f
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/tick_task_scheduler.sv
verif/tts_reply_checker.sv
verif/tb_top.sv
